// File: rtl/core/sfe_pkg.sv
// Shared types and constants for the serial command frame encoder.
// Used by every module in rtl/core; depends on nothing else.
package sfe_pkg;

    localparam int POS_W          = 12;
    localparam int PROD_W         = 2 * POS_W;
    localparam int STEP_W         = $clog2(PROD_W);
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] HDR_BYTE  = 8'hFE;
    localparam logic [7:0] LEN_SHORT = 8'h04;
    localparam logic [7:0] LEN_DATE  = 8'h05;
    localparam logic [7:0] CMD_TOUCH = 8'hA1;
    localparam logic [7:0] CMD_TIME  = 8'hA4;
    localparam logic [7:0] CMD_DATE  = 8'hA5;

    localparam logic [POS_W-1:0] YEAR_BASE = 12'd2000;
    localparam logic [POS_W-1:0] SCALE_SAT = 12'hFFF;

    localparam logic [1:0] KIND_TOUCH = 2'd0;
    localparam logic [1:0] KIND_TIME  = 2'd1;
    localparam logic [1:0] KIND_DATE  = 2'd2;

    localparam logic [2:0] REG_ENABLE        = 3'd0;
    localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd1;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd2;
    localparam logic [2:0] REG_TARGET_WIDTH  = 3'd3;
    localparam logic [2:0] REG_TARGET_HEIGHT = 3'd4;

    localparam logic [POS_W-1:0] SCREEN_WIDTH_RST  = 12'd800;
    localparam logic [POS_W-1:0] SCREEN_HEIGHT_RST = 12'd480;
    localparam logic [POS_W-1:0] TARGET_WIDTH_RST  = 12'd800;
    localparam logic [POS_W-1:0] TARGET_HEIGHT_RST = 12'd480;

    // One frame as it waits between the front and the back end. The header
    // and checksum are added by the back end.
    typedef struct packed {
        logic [7:0]      len;
        logic [7:0]      cmd;
        logic [3:0][7:0] payload;
    } frame_t;

endpackage

// File: rtl/core/serial_command_frame_encoder.sv
// Top level of the serial command frame encoder: register port and the
// front end, frame queue and back end. Depends on sfe_pkg, sfe_front,
// sfe_queue and sfe_back.
//
//   Channel   Handshake                     Payload
//   command   start / busy                  kind, touch_x .. weekday_value
//   result    result_valid (strobe)         out_byte, frame_end
//   config    psel, penable, pwrite, pready paddr, pwdata, prdata
//
// Time and date commands go into the queue in the cycle they are taken. A touch
// command keeps busy high through one multiply, 24 restoring division steps and
// a push that waits while the queue is full; no new command is taken meanwhile.
// Frames leave at one byte a cycle: 7 bytes for touch and time, 8 for date,
// with no gap between queued frames. busy is high while the front end works or
// the queue is full. The receiver cannot stall, so each byte is shown once.
// Reset empties the queue and restores the register defaults; enable resets low.
module serial_command_frame_encoder #(
    parameter int QUEUE_DEPTH = sfe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [11:0] touch_x,
    input  logic [11:0] touch_y,
    input  logic [7:0]  hour_value,
    input  logic [7:0]  minute_value,
    input  logic [7:0]  time_format,
    input  logic [11:0] year_value,
    input  logic [7:0]  month_value,
    input  logic [7:0]  day_value,
    input  logic [7:0]  weekday_value,
    output logic        result_valid,
    output logic [7:0]  out_byte,
    output logic        frame_end
);
    import sfe_pkg::*;

    logic              enable_reg;
    logic [POS_W-1:0]  screen_width_reg, screen_height_reg;
    logic [POS_W-1:0]  target_width_reg, target_height_reg;
    logic [2:0]        reg_idx;
    logic              wr_en;
    logic              q_full, q_valid, push, pop;
    frame_t            push_frame, q_data;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg        <= 1'b0;
            screen_width_reg  <= SCREEN_WIDTH_RST;
            screen_height_reg <= SCREEN_HEIGHT_RST;
            target_width_reg  <= TARGET_WIDTH_RST;
            target_height_reg <= TARGET_HEIGHT_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_ENABLE:        enable_reg        <= pwdata[0];
                REG_SCREEN_WIDTH:  screen_width_reg  <= pwdata[POS_W-1:0];
                REG_SCREEN_HEIGHT: screen_height_reg <= pwdata[POS_W-1:0];
                REG_TARGET_WIDTH:  target_width_reg  <= pwdata[POS_W-1:0];
                REG_TARGET_HEIGHT: target_height_reg <= pwdata[POS_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ENABLE:        prdata = {31'd0, enable_reg};
            REG_SCREEN_WIDTH:  prdata = {20'd0, screen_width_reg};
            REG_SCREEN_HEIGHT: prdata = {20'd0, screen_height_reg};
            REG_TARGET_WIDTH:  prdata = {20'd0, target_width_reg};
            REG_TARGET_HEIGHT: prdata = {20'd0, target_height_reg};
            default:           prdata = '0;
        endcase
    end

    sfe_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .enable        (enable_reg),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .target_width  (target_width_reg),
        .target_height (target_height_reg),
        .kind          (kind),
        .touch_x       (touch_x),
        .touch_y       (touch_y),
        .hour_value    (hour_value),
        .minute_value  (minute_value),
        .time_format   (time_format),
        .year_value    (year_value),
        .month_value   (month_value),
        .day_value     (day_value),
        .weekday_value (weekday_value),
        .q_full        (q_full),
        .push          (push),
        .push_frame    (push_frame)
    );

    sfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .q_full     (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_data     (q_data)
    );

    sfe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .pop          (pop),
        .result_valid (result_valid),
        .out_byte     (out_byte),
        .frame_end    (frame_end)
    );

endmodule

// File: rtl/core/sfe_front.sv
// Front end: accepts commands, scales touch positions and builds frames.
// Depends on sfe_pkg.
module sfe_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    enable,
    input  logic [sfe_pkg::POS_W-1:0] screen_width,
    input  logic [sfe_pkg::POS_W-1:0] screen_height,
    input  logic [sfe_pkg::POS_W-1:0] target_width,
    input  logic [sfe_pkg::POS_W-1:0] target_height,
    input  logic [1:0]              kind,
    input  logic [sfe_pkg::POS_W-1:0] touch_x,
    input  logic [sfe_pkg::POS_W-1:0] touch_y,
    input  logic [7:0]              hour_value,
    input  logic [7:0]              minute_value,
    input  logic [7:0]              time_format,
    input  logic [sfe_pkg::POS_W-1:0] year_value,
    input  logic [7:0]              month_value,
    input  logic [7:0]              day_value,
    input  logic [7:0]              weekday_value,
    input  logic                    q_full,
    output logic                    push,
    output sfe_pkg::frame_t         push_frame
);
    import sfe_pkg::*;

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_DIV, F_PUSH} state_t;

    state_t              state_reg, state_next;
    logic [POS_W-1:0]    px_reg, px_next, py_reg, py_next;
    logic [PROD_W-1:0]   wx_reg, wx_next, wy_reg, wy_next;
    logic [POS_W-1:0]    rx_reg, rx_next, ry_reg, ry_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [POS_W-1:0]    qx, qy;
    logic [POS_W-1:0]    year_off;

    // One restoring division step: remainder in the upper part, dividend
    // bits leaving and quotient bits entering the lower part.
    function automatic logic [POS_W+PROD_W-1:0] div_step(
        input logic [POS_W-1:0]  rem,
        input logic [PROD_W-1:0] work,
        input logic [POS_W-1:0]  div
    );
        logic [POS_W:0]   trial;
        logic [POS_W:0]   diff;
        logic             qbit;
        trial = {rem, work[PROD_W-1]};
        diff  = trial - {1'b0, div};
        qbit  = (trial >= {1'b0, div});
        if (qbit)
        begin
            return {diff[POS_W-1:0], work[PROD_W-2:0], 1'b1};
        end
        return {trial[POS_W-1:0], work[PROD_W-2:0], 1'b0};
    endfunction

    always_comb
    begin
        state_next = state_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        wx_next    = wx_reg;
        wy_next    = wy_reg;
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        step_next  = step_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (start && !q_full && enable && kind == KIND_TOUCH)
                begin
                    px_next    = touch_x;
                    py_next    = touch_y;
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                wx_next    = PROD_W'(px_reg) * PROD_W'(target_width);
                wy_next    = PROD_W'(py_reg) * PROD_W'(target_height);
                rx_next    = '0;
                ry_next    = '0;
                step_next  = '0;
                state_next = F_DIV;
            end
            F_DIV:
            begin
                {rx_next, wx_next} = div_step(rx_reg, wx_reg, screen_width);
                {ry_next, wy_next} = div_step(ry_reg, wy_reg, screen_height);
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(PROD_W - 1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // A zero divisor gives an all-ones answer, as the divider hardware would.
    assign qx = (screen_width == '0)  ? SCALE_SAT : wx_reg[POS_W-1:0];
    assign qy = (screen_height == '0) ? SCALE_SAT : wy_reg[POS_W-1:0];
    assign year_off = year_value - YEAR_BASE;

    always_comb
    begin
        push_frame = '0;
        if (state_reg == F_PUSH)
        begin
            push_frame.len        = LEN_SHORT;
            push_frame.cmd        = CMD_TOUCH;
            push_frame.payload[0] = qx[7:0];
            push_frame.payload[1] = {qx[11:8], qy[11:8]};
            push_frame.payload[2] = qy[7:0];
        end
        else if (kind == KIND_DATE)
        begin
            push_frame.len        = LEN_DATE;
            push_frame.cmd        = CMD_DATE;
            push_frame.payload[0] = year_off[7:0];
            push_frame.payload[1] = month_value;
            push_frame.payload[2] = day_value;
            push_frame.payload[3] = weekday_value;
        end
        else
        begin
            push_frame.len        = LEN_SHORT;
            push_frame.cmd        = CMD_TIME;
            push_frame.payload[0] = hour_value;
            push_frame.payload[1] = minute_value;
            push_frame.payload[2] = time_format;
        end
    end

    assign busy = (state_reg != F_IDLE) || q_full;
    assign push = (state_reg == F_PUSH && !q_full)
               || (state_reg == F_IDLE && start && !q_full && enable
                   && (kind == KIND_TIME || kind == KIND_DATE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg <= px_next;
        py_reg <= py_next;
        wx_reg <= wx_next;
        wy_reg <= wy_next;
        rx_reg <= rx_next;
        ry_reg <= ry_next;
    end

endmodule

// File: rtl/core/sfe_queue.sv
// Short frame queue between the front and the back end.
// Depends on sfe_pkg.
module sfe_queue #(
    parameter int DEPTH = sfe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sfe_pkg::frame_t push_frame,
    output logic            q_full,
    input  logic            pop,
    output logic            q_valid,
    output sfe_pkg::frame_t q_data
);
    import sfe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_frame;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("frame pushed into a full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("frame popped from an empty queue");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue fill count lost a push");

endmodule

// File: rtl/core/sfe_back.sv
// Back end: sends each queued frame byte by byte with a running checksum.
// Depends on sfe_pkg.
module sfe_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  sfe_pkg::frame_t q_data,
    output logic            pop,
    output logic            result_valid,
    output logic [7:0]      out_byte,
    output logic            frame_end
);
    import sfe_pkg::*;

    logic        active_reg;
    logic [2:0]  idx_reg;
    logic [7:0]  sum_reg;
    frame_t      cur_reg;
    logic [7:0]  byte_sel;
    logic        last;

    always_comb
    begin
        case (idx_reg)
            3'd0:    byte_sel = HDR_BYTE;
            3'd1:    byte_sel = cur_reg.len;
            3'd2:    byte_sel = cur_reg.cmd;
            3'd3:    byte_sel = cur_reg.payload[0];
            3'd4:    byte_sel = cur_reg.payload[1];
            3'd5:    byte_sel = cur_reg.payload[2];
            3'd6:    byte_sel = cur_reg.payload[3];
            default: byte_sel = '0;
        endcase
    end

    // The checksum follows the payload: its index is the length byte plus two.
    assign last         = active_reg && (idx_reg == cur_reg.len[2:0] + 3'd2);
    assign result_valid = active_reg;
    assign frame_end    = last;
    assign out_byte     = last ? (8'd0 - sum_reg) : byte_sel;
    assign pop          = q_valid && (!active_reg || last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
            sum_reg    <= '0;
        end
        else if (pop)
        begin
            active_reg <= 1'b1;
            idx_reg    <= '0;
            sum_reg    <= '0;
        end
        else if (last)
        begin
            active_reg <= 1'b0;
        end
        else if (active_reg)
        begin
            idx_reg <= idx_reg + 1'b1;
            sum_reg <= sum_reg + byte_sel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= q_data;
        end
    end

    a_frame_whole: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !frame_end) |=> result_valid)
        else $error("frame broken off before its checksum");
    a_idle_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_end && !q_valid) |=> !result_valid)
        else $error("byte sent with no frame queued");
    a_header_first: assert property (@(posedge clk) disable iff (!rst_n)
        $past(pop) |-> (result_valid && out_byte == HDR_BYTE))
        else $error("frame does not open with the header byte");

endmodule

// File: test/tb_serial_command_frame_encoder.sv
// Self-checking testbench for the serial command frame encoder: drives commands and
// register writes, predicts every frame byte and checks the result stream.
// Depends on sfe_pkg and serial_command_frame_encoder from rtl/core.
module tb_serial_command_frame_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    import sfe_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 48;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] x;
        logic [11:0] y;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  fmt;
        logic [11:0] year;
        logic [7:0]  month;
        logic [7:0]  day;
        logic [7:0]  weekday;
    } command_t;

    // Holds the bytes that the encoder owes us, worked out from the register
    // copies at the moment each command transaction is accepted.
    class frame_scoreboard;
        typedef struct packed {
            logic [7:0] data;
            logic       last;
        } frame_byte_t;

        frame_byte_t owed_bytes[$];
        bit          port_open;
        logic [11:0] src_w;
        logic [11:0] src_h;
        logic [11:0] dst_w;
        logic [11:0] dst_h;
        int          errors;

        function new();
            port_open = 1'b0;
            src_w     = SCREEN_WIDTH_RST;
            src_h     = SCREEN_HEIGHT_RST;
            dst_w     = TARGET_WIDTH_RST;
            dst_h     = TARGET_HEIGHT_RST;
            errors    = 0;
        endfunction

        function void write_reg(input logic [2:0] idx, input logic [31:0] value);
            case (idx)
                REG_ENABLE:        port_open = value[0];
                REG_SCREEN_WIDTH:  src_w = value[11:0];
                REG_SCREEN_HEIGHT: src_h = value[11:0];
                REG_TARGET_WIDTH:  dst_w = value[11:0];
                REG_TARGET_HEIGHT: dst_h = value[11:0];
                default: ;
            endcase
        endfunction

        function logic [11:0] scale(input logic [11:0] pos, input logic [11:0] mul,
                                    input logic [11:0] div);
            logic [23:0] prod;
            logic [23:0] quot;
            if (div == 12'd0)
                return SCALE_SAT;
            prod = pos * mul;
            quot = prod / div;
            return quot[11:0];
        endfunction

        function void note_command(input command_t c);
            logic [7:0]  body[7];
            logic [11:0] sx;
            logic [11:0] sy;
            logic [11:0] year_off;
            logic [7:0]  sum;
            int          count;
            if (!port_open || c.kind == KIND_UNUSED)
                return;
            body[0] = HDR_BYTE;
            case (c.kind)
                KIND_TOUCH: begin
                    sx = scale(c.x, dst_w, src_w);
                    sy = scale(c.y, dst_h, src_h);
                    body[1] = LEN_SHORT;
                    body[2] = CMD_TOUCH;
                    body[3] = sx[7:0];
                    body[4] = {sx[11:8], sy[11:8]};
                    body[5] = sy[7:0];
                    count   = 6;
                end
                KIND_TIME: begin
                    body[1] = LEN_SHORT;
                    body[2] = CMD_TIME;
                    body[3] = c.hour;
                    body[4] = c.minute;
                    body[5] = c.fmt;
                    count   = 6;
                end
                default: begin
                    year_off = c.year - YEAR_BASE;
                    body[1]  = LEN_DATE;
                    body[2]  = CMD_DATE;
                    body[3]  = year_off[7:0];
                    body[4]  = c.month;
                    body[5]  = c.day;
                    body[6]  = c.weekday;
                    count    = 7;
                end
            endcase
            sum = 8'd0;
            for (int i = 0; i < count; i++)
            begin
                sum = sum + body[i];
                owed_bytes.push_back('{data: body[i], last: 1'b0});
            end
            owed_bytes.push_back('{data: 8'(8'd0 - sum), last: 1'b1});
        endfunction

        function void check_byte(input logic [7:0] data, input logic last);
            frame_byte_t want;
            if (owed_bytes.size() == 0)
            begin
                $error("out_byte: no transaction expected, got %h (frame_end %b)",
                       data, last);
                errors++;
                return;
            end
            want = owed_bytes.pop_front();
            if (data !== want.data)
            begin
                $error("out_byte: expected %h, got %h", want.data, data);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("frame_end: expected %b, got %b", want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return owed_bytes.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic [1:0]  kind;
    logic [11:0] touch_x;
    logic [11:0] touch_y;
    logic [7:0]  hour_value;
    logic [7:0]  minute_value;
    logic [7:0]  time_format;
    logic [11:0] year_value;
    logic [7:0]  month_value;
    logic [7:0]  day_value;
    logic [7:0]  weekday_value;
    logic        result_valid;
    logic [7:0]  out_byte;
    logic        frame_end;

    frame_scoreboard sb = new();

    serial_command_frame_encoder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .touch_x       (touch_x),
        .touch_y       (touch_y),
        .hour_value    (hour_value),
        .minute_value  (minute_value),
        .time_format   (time_format),
        .year_value    (year_value),
        .month_value   (month_value),
        .day_value     (day_value),
        .weekday_value (weekday_value),
        .result_valid  (result_valid),
        .out_byte      (out_byte),
        .frame_end     (frame_end)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Both sides are sampled at the edge, before the design's own updates land.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_command('{kind, touch_x, touch_y, hour_value, minute_value,
                                  time_format, year_value, month_value, day_value,
                                  weekday_value});
            if (result_valid)
                sb.check_byte(out_byte, frame_end);
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_sizes(input logic [11:0] sw, input logic [11:0] sh,
                               input logic [11:0] tw, input logic [11:0] th);
        write_reg(REG_SCREEN_WIDTH, {20'd0, sw});
        write_reg(REG_SCREEN_HEIGHT, {20'd0, sh});
        write_reg(REG_TARGET_WIDTH, {20'd0, tw});
        write_reg(REG_TARGET_HEIGHT, {20'd0, th});
    endtask

    // A command may still be in the front end even when it owes no bytes, so a
    // fixed settling time follows once the owed bytes have all arrived.
    task automatic wait_until_quiet();
        start <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0 || busy);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_command(input command_t c, input int idle_pct);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct && gap < 12)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        kind          <= c.kind;
        touch_x       <= c.x;
        touch_y       <= c.y;
        hour_value    <= c.hour;
        minute_value  <= c.minute;
        time_format   <= c.fmt;
        year_value    <= c.year;
        month_value   <= c.month;
        day_value     <= c.day;
        weekday_value <= c.weekday;
        start         <= 1'b1;
        do @(posedge clk); while (busy);
    endtask

    function automatic command_t make_cmd(input logic [1:0] k, input logic [11:0] a,
                                          input logic [11:0] b, input logic [7:0] p,
                                          input logic [7:0] q, input logic [7:0] r);
        command_t c;
        c = '{k, a, b, p, q, r, a, p, q, r};
        if (k == KIND_TIME)
            c.hour = a[7:0];
        return c;
    endfunction

    function automatic command_t random_command();
        command_t c;
        c.kind    = ($urandom_range(19) == 0) ? KIND_UNUSED : 2'($urandom_range(2));
        c.x       = ($urandom_range(7) == 0) ? 12'hFFF : 12'($urandom_range(4095));
        c.y       = ($urandom_range(7) == 0) ? 12'd0 : 12'($urandom_range(4095));
        c.hour    = 8'($urandom_range(255));
        c.minute  = 8'($urandom_range(255));
        c.fmt     = 8'($urandom_range(255));
        c.year    = ($urandom_range(4) == 0) ? 12'($urandom_range(4095))
                                             : 12'($urandom_range(2255, 2000));
        c.month   = 8'($urandom_range(255));
        c.day     = 8'($urandom_range(255));
        c.weekday = 8'($urandom_range(255));
        return c;
    endfunction

    function automatic logic [11:0] pick_size(input bit is_divisor);
        case ($urandom_range(7))
            0: return 12'd1;
            1: return 12'hFFF;
            2: return is_divisor ? 12'd0 : 12'd0;
            3: return is_divisor ? 12'($urandom_range(1023, 1)) : 12'($urandom_range(4095));
            default: return 12'($urandom_range(4095));
        endcase
    endfunction

    initial
    begin
        int idle_pct;
        int drain_limit;
        rst_n   <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        start   <= 1'b0;
        kind    <= KIND_TOUCH;
        touch_x <= '0;
        touch_y <= '0;
        hour_value    <= '0;
        minute_value  <= '0;
        time_format   <= '0;
        year_value    <= YEAR_BASE;
        month_value   <= '0;
        day_value     <= '0;
        weekday_value <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The port comes out of reset closed, so nothing may be emitted.
        send_command(make_cmd(KIND_TOUCH, 12'd100, 12'd200, 8'd1, 8'd2, 8'd3), 0);
        send_command(make_cmd(KIND_DATE, 12'd2024, 12'd0, 8'd5, 8'd6, 8'd7), 0);
        wait_until_quiet();

        // Default sizes after reset, field extremes and the unused kind.
        write_reg(REG_ENABLE, 32'd1);
        send_command(make_cmd(KIND_TOUCH, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0), 0);
        send_command(make_cmd(KIND_TOUCH, 12'hFFF, 12'hFFF, 8'd0, 8'd0, 8'd0), 0);
        send_command(make_cmd(KIND_TOUCH, 12'd799, 12'd479, 8'd0, 8'd0, 8'd0), 0);
        send_command(make_cmd(KIND_TIME, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0), 0);
        send_command(make_cmd(KIND_TIME, 12'd255, 12'd0, 8'hFF, 8'hFF, 8'hFF), 0);
        send_command(make_cmd(KIND_DATE, 12'd2000, 12'd0, 8'd0, 8'd0, 8'd0), 0);
        send_command(make_cmd(KIND_DATE, 12'd2255, 12'd0, 8'hFF, 8'hFF, 8'hFF), 0);
        send_command(make_cmd(KIND_DATE, 12'd0, 12'd0, 8'd12, 8'd31, 8'd6), 0);
        send_command(make_cmd(KIND_DATE, 12'hFFF, 12'd0, 8'd1, 8'd1, 8'd0), 0);
        send_command(make_cmd(KIND_UNUSED, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'hFF), 0);
        wait_until_quiet();

        // Zero divisors give all ones; a unit divisor overflows the 12-bit result.
        write_sizes(12'd0, 12'd0, 12'hFFF, 12'hFFF);
        send_command(make_cmd(KIND_TOUCH, 12'hFFF, 12'd0, 8'd0, 8'd0, 8'd0), 0);
        send_command(make_cmd(KIND_TOUCH, 12'd123, 12'hFFF, 8'd0, 8'd0, 8'd0), 0);
        wait_until_quiet();
        write_sizes(12'd1, 12'd1, 12'hFFF, 12'hFFF);
        send_command(make_cmd(KIND_TOUCH, 12'hFFF, 12'hFFF, 8'd0, 8'd0, 8'd0), 0);
        send_command(make_cmd(KIND_TOUCH, 12'd1, 12'd2, 8'd0, 8'd0, 8'd0), 0);
        wait_until_quiet();
        write_sizes(12'hFFF, 12'hFFF, 12'd0, 12'd0);
        send_command(make_cmd(KIND_TOUCH, 12'hFFF, 12'hFFF, 8'd0, 8'd0, 8'd0), 0);
        wait_until_quiet();

        write_reg(REG_ENABLE, 32'd0);
        send_command(make_cmd(KIND_TOUCH, 12'd5, 12'd5, 8'd0, 8'd0, 8'd0), 0);
        send_command(make_cmd(KIND_TIME, 12'd9, 12'd0, 8'd9, 8'd9, 8'd9), 0);
        send_command(make_cmd(KIND_DATE, 12'd2030, 12'd0, 8'd3, 8'd4, 8'd5), 0);
        wait_until_quiet();

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 36 : (phase == 1) ? 66 : 0;
            for (int setting = 0; setting < 4; setting++)
            begin
                write_reg(REG_ENABLE, {31'd0, ($urandom_range(7) != 0)});
                write_sizes(pick_size(1'b1), pick_size(1'b1),
                            pick_size(1'b0), pick_size(1'b0));
                for (int n = 0; n < 40; n++)
                    send_command(random_command(), idle_pct);
                wait_until_quiet();
            end
        end

        drain_limit = 0;
        while (sb.pending() != 0 && drain_limit < 2000)
        begin
            @(posedge clk);
            drain_limit++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("out_byte: %0d expected bytes never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// File: serial_command_frame_encoder.f
rtl/core/sfe_pkg.sv
rtl/core/sfe_front.sv
rtl/core/sfe_queue.sv
rtl/core/sfe_back.sv
rtl/core/serial_command_frame_encoder.sv
test/tb_serial_command_frame_encoder.sv
